>>> rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, types, angle constants and the arctangent table for the
// cartesian to spherical converter.
// ----------------------------------------------------------------------------
package c2s_pkg;

   localparam int XW           = 32;  // coordinate and result field width
   localparam int IW           = 34;  // angle unit operand width
   localparam int PW           = 35;  // width after the quarter turn
   localparam int CW           = 64;  // cordic datapath width
   localparam int AW           = 35;  // angle accumulator width
   localparam int RW           = 35;  // square root remainder width
   localparam int SQ_STEPS     = 32;
   localparam int CORDIC_STEPS = 32;
   localparam int NORM_TOP     = 58;  // normalized magnitude has its msb here
   localparam int NSTG         = 72;  // register stages ahead of the output buffer
   localparam int XYZ_DLY      = 36;
   localparam int R_DLY        = 35;

   localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(64'h4000_0000);
   localparam logic signed [AW-1:0] ANG_PI      = AW'(64'h8000_0000);

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [63:0]   rad;
      logic [RW-1:0] rem;
      logic [31:0]   root;
   } sqrt_type;

   typedef struct packed {
      logic signed [CW-1:0] n;
      logic signed [CW-1:0] d;
      logic signed [AW-1:0] acc;
      logic                 hold;
   } ang_type;

   typedef struct packed {
      logic [XW-1:0] lon;
      logic [XW-1:0] lat;
      logic [XW-1:0] rad;
   } res_type;

   function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
      atan_entry = signed'({{(AW-32){1'b0}}, ATAN_TAB[idx]});
   endfunction

   function automatic logic [5:0] msb_index(input logic [IW-1:0] m);
      logic [5:0] idx;
      idx = '0;
      for (int k = 0; k < IW; k++) begin
         if (m[k]) begin
            idx = 6'(k);
         end
      end
      msb_index = idx;
   endfunction

endpackage

>>> rtl/c2s_sqrt_cell.sv
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One restoring square root step: brings in two radicand bits, settles one
// root bit.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell import c2s_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type cell_in,
   output sqrt_type cell_out
);

   sqrt_type      cell_ff, cell_in_nx;
   logic [RW-1:0] rem_sh, trial;

   always_comb begin
      rem_sh         = {cell_in.rem[RW-3:0], cell_in.rad[63:62]};
      trial          = {1'b0, cell_in.root, 2'b01};
      cell_in_nx.rad = {cell_in.rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in_nx.rem  = rem_sh - trial;
         cell_in_nx.root = {cell_in.root[30:0], 1'b1};
      end else begin
         cell_in_nx.rem  = rem_sh;
         cell_in_nx.root = {cell_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/c2s_angle_prep.sv
// ----------------------------------------------------------------------------
// c2s_angle_prep
// Three stage front end of the vectoring unit: axis cases and quarter turn,
// leading one search, normalizing shift.
// ----------------------------------------------------------------------------
module c2s_angle_prep import c2s_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [IW-1:0] n_in,
   input  logic signed [IW-1:0] d_in,
   output ang_type              prep_out
);

   logic signed [PW-1:0] n_e, d_e, n1_in, d1_in, n1_ff, d1_ff, n2_ff, d2_ff;
   logic signed [AW-1:0] acc1_in, acc1_ff, acc2_ff;
   logic                 hold1_in, hold1_ff, hold2_ff;
   logic [IW-1:0]        m1_in, m1_ff, mag_n, mag_d;
   logic [5:0]           s2_in, s2_ff;
   logic signed [PW-1:0] neg_n, neg_d;
   ang_type              out_ff, out_in;

   assign n_e   = {n_in[IW-1], n_in};
   assign d_e   = {d_in[IW-1], d_in};
   assign neg_n = -n_e;
   assign neg_d = -d_e;

   always_comb begin
      hold1_in = 1'b0;
      n1_in    = n_e;
      d1_in    = d_e;
      acc1_in  = '0;
      priority if (n_in == '0) begin
         hold1_in = 1'b1;
         acc1_in  = d_in[IW-1] ? ANG_PI : '0;
      end else if (d_in == '0) begin
         hold1_in = 1'b1;
         acc1_in  = n_in[IW-1] ? -ANG_HALF_PI : ANG_HALF_PI;
      end else if (d_in[IW-1]) begin
         // quarter turn into the right half plane
         if (!n_in[IW-1]) begin
            d1_in   = n_e;
            n1_in   = neg_d;
            acc1_in = ANG_HALF_PI;
         end else begin
            d1_in   = neg_n;
            n1_in   = d_e;
            acc1_in = -ANG_HALF_PI;
         end
      end else begin
         acc1_in = '0;
      end
      mag_n = n1_in[PW-1] ? IW'(-n1_in) : n1_in[IW-1:0];
      mag_d = d1_in[PW-1] ? IW'(-d1_in) : d1_in[IW-1:0];
      m1_in = mag_n | mag_d;
   end

   assign s2_in = 6'(NORM_TOP) - msb_index(m1_ff);

   always_comb begin
      out_in.n    = {{(CW-PW){n2_ff[PW-1]}}, n2_ff} <<< s2_ff;
      out_in.d    = {{(CW-PW){d2_ff[PW-1]}}, d2_ff} <<< s2_ff;
      out_in.acc  = acc2_ff;
      out_in.hold = hold2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff    <= n1_in;
         d1_ff    <= d1_in;
         acc1_ff  <= acc1_in;
         hold1_ff <= hold1_in;
         m1_ff    <= m1_in;
         n2_ff    <= n1_ff;
         d2_ff    <= d1_ff;
         acc2_ff  <= acc1_ff;
         hold2_ff <= hold1_ff;
         s2_ff    <= s2_in;
         out_ff   <= out_in;
      end
   end

   assign prep_out = out_ff;

endmodule

>>> rtl/c2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring rotation: drives n toward zero and sums the table angle.
// ----------------------------------------------------------------------------
module c2s_cordic_cell import c2s_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] step_idx,
   input  ang_type    cell_in,
   output ang_type    cell_out
);

   ang_type              cell_ff, cell_in_nx;
   logic signed [CW-1:0] sn, sd;
   logic signed [AW-1:0] tab;

   assign sn  = cell_in.n >>> step_idx;
   assign sd  = cell_in.d >>> step_idx;
   assign tab = atan_entry(step_idx);

   always_comb begin
      cell_in_nx = cell_in;
      if (!cell_in.hold) begin
         if (!cell_in.n[CW-1] && (cell_in.n != '0)) begin
            cell_in_nx.d   = cell_in.d + sn;
            cell_in_nx.n   = cell_in.n - sd;
            cell_in_nx.acc = cell_in.acc + tab;
         end else begin
            cell_in_nx.d   = cell_in.d - sn;
            cell_in_nx.n   = cell_in.n + sd;
            cell_in_nx.acc = cell_in.acc - tab;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/cartesian_to_spherical.sv
// An accepted transaction passes through every register stage before its
// result reaches the output, and is held back further while the result side stalls.
// Throughput: one transaction per cycle; the whole cell chain advances
// together and holds only once both output buffer entries are waiting.
// Reset clears the stage valid bits and the output buffer count.
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Squares, two square root cell chains, then two cordic vectoring chains for
// longitude and latitude.
// ----------------------------------------------------------------------------
module cartesian_to_spherical import c2s_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [XW-1:0] req_pos_x,
   input  logic signed [XW-1:0] req_pos_y,
   input  logic signed [XW-1:0] req_pos_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [XW-1:0] rsp_longitude,
   output logic signed [XW-1:0] rsp_latitude,
   output logic [XW-1:0]        rsp_radius
);

   logic                 en, push, pop;
   logic [NSTG-1:0]      vld_ff;
   logic signed [XW-1:0] x_ff, y_ff, z_ff;
   logic [XW-1:0]        ax, ay, az;
   logic [63:0]          sqx_ff, sqy_ff, sqz_ff, hsq3_ff, sqz3_ff, hsq4_ff, rsq4_ff;
   logic [3*XW-1:0]      xyz_dly_ff [XYZ_DLY];
   logic [XW-1:0]        r_dly_ff [R_DLY];
   sqrt_type             h_chain [SQ_STEPS+1];
   sqrt_type             r_chain [SQ_STEPS+1];
   logic [XW-1:0]        h_ff, r_ff, h_in, r_in;
   logic signed [XW-1:0] x37, y37, z37;
   ang_type              lon_chain [CORDIC_STEPS+1];
   ang_type              lat_chain [CORDIC_STEPS+1];
   logic signed [AW-1:0] lat_raw;
   res_type              fin, head_ff, head_in, tail_ff, tail_in;
   logic [1:0]           cnt_ff, cnt_in;

   assign en        = (cnt_ff != 2'd2);
   assign req_stall = !en;
   assign push      = en && vld_ff[NSTG-1];
   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   // squares and sums ahead of the root chains
   assign ax = x_ff[XW-1] ? (~x_ff + 1'b1) : x_ff;
   assign ay = y_ff[XW-1] ? (~y_ff + 1'b1) : y_ff;
   assign az = z_ff[XW-1] ? (~z_ff + 1'b1) : z_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         z_ff    <= req_pos_z;
         sqx_ff  <= 64'(ax) * 64'(ax);
         sqy_ff  <= 64'(ay) * 64'(ay);
         sqz_ff  <= 64'(az) * 64'(az);
         hsq3_ff <= sqx_ff + sqy_ff;
         sqz3_ff <= sqz_ff;
         hsq4_ff <= hsq3_ff;
         rsq4_ff <= hsq3_ff + sqz3_ff;
         xyz_dly_ff[0] <= {x_ff, y_ff, z_ff};
         for (int k = 1; k < XYZ_DLY; k++) begin
            xyz_dly_ff[k] <= xyz_dly_ff[k-1];
         end
         h_ff <= h_in;
         r_ff <= r_in;
         r_dly_ff[0] <= r_ff;
         for (int k = 1; k < R_DLY; k++) begin
            r_dly_ff[k] <= r_dly_ff[k-1];
         end
      end
   end

   assign h_chain[0] = '{rad: hsq4_ff, rem: '0, root: '0};
   assign r_chain[0] = '{rad: rsq4_ff, rem: '0, root: '0};

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
      c2s_sqrt_cell u_h (
         .clock(clock), .en(en), .cell_in(h_chain[g]), .cell_out(h_chain[g+1])
      );
      c2s_sqrt_cell u_r (
         .clock(clock), .en(en), .cell_in(r_chain[g]), .cell_out(r_chain[g+1])
      );
   end

   // round to nearest: up when the remainder exceeds the root
   assign h_in = h_chain[SQ_STEPS].root
               + XW'(h_chain[SQ_STEPS].rem > RW'(h_chain[SQ_STEPS].root));
   assign r_in = r_chain[SQ_STEPS].root
               + XW'(r_chain[SQ_STEPS].rem > RW'(r_chain[SQ_STEPS].root));

   assign {x37, y37, z37} = xyz_dly_ff[XYZ_DLY-1];

   c2s_angle_prep u_lon_prep (
      .clock(clock), .en(en),
      .n_in({{(IW-XW){y37[XW-1]}}, y37}),
      .d_in({{(IW-XW){x37[XW-1]}}, x37}),
      .prep_out(lon_chain[0])
   );

   c2s_angle_prep u_lat_prep (
      .clock(clock), .en(en),
      .n_in({{(IW-XW){1'b0}}, h_ff}),
      .d_in({{(IW-XW){z37[XW-1]}}, z37}),
      .prep_out(lat_chain[0])
   );

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      c2s_cordic_cell u_lon (
         .clock(clock), .en(en), .step_idx(5'(g)),
         .cell_in(lon_chain[g]), .cell_out(lon_chain[g+1])
      );
      c2s_cordic_cell u_lat (
         .clock(clock), .en(en), .step_idx(5'(g)),
         .cell_in(lat_chain[g]), .cell_out(lat_chain[g+1])
      );
   end

   assign lat_raw = ANG_HALF_PI - lat_chain[CORDIC_STEPS].acc;

   always_comb begin
      fin.lon = lon_chain[CORDIC_STEPS].acc[XW-1:0];
      fin.rad = r_dly_ff[R_DLY-1];
      priority if (lat_raw > ANG_HALF_PI) begin
         fin.lat = ANG_HALF_PI[XW-1:0];
      end else if (lat_raw < -ANG_HALF_PI) begin
         fin.lat = XW'(-ANG_HALF_PI);
      end else begin
         fin.lat = lat_raw[XW-1:0];
      end
   end

   // two entry output buffer
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            head_in = tail_ff;
         end else if (push) begin
            head_in = fin;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_in = fin;
         end else begin
            tail_in = fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid     = (cnt_ff != 2'd0);
   assign rsp_longitude = head_ff.lon;
   assign rsp_latitude  = head_ff.lat;
   assign rsp_radius    = head_ff.rad;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("output buffer count out of range");

   a_freeze_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |=> (vld_ff == $past(vld_ff)))
      else $error("cell chain moved while output buffer full");

   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_latitude <= 32'sd1073741824) &&
                     (rsp_latitude >= -32'sd1073741824)))
      else $error("latitude outside quarter turn");
`endif

endmodule

>>> verif/tb_cartesian_to_spherical.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical
// Drives earth-centred points into the converter under random sender and
// receiver idling, predicts longitude, latitude and radius with an
// independent cordic and rounded square root, and checks every result in
// order.
// ----------------------------------------------------------------------------
module tb_cartesian_to_spherical;
   import c2s_pkg::*;

   typedef struct {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [XW-1:0] z;
      bit                   drain;  // hold off until every result is back
   } point_type;

   typedef struct {
      logic [XW-1:0] lon;
      logic [XW-1:0] lat;
      logic [XW-1:0] rad;
   } coords_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 830;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [XW-1:0] req_pos_x;
   logic signed [XW-1:0] req_pos_y;
   logic signed [XW-1:0] req_pos_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [XW-1:0] rsp_longitude;
   logic signed [XW-1:0] rsp_latitude;
   logic [XW-1:0]        rsp_radius;

   point_type  pending_points[$];
   coords_type expected_coords[$];
   int         n_errors   = 0;
   int         n_sent     = 0;
   int         n_checked  = 0;
   int         n_planned  = 0;
   int         cycles     = 0;
   int         phase;

   cartesian_to_spherical dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // rounded to nearest integer square root
   function automatic longint unsigned root_nearest(input longint unsigned v);
      longint unsigned rem, r, b;
      rem = v;
      r   = 0;
      b   = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return (rem > r) ? r + 1 : r;
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(64'd0 - v) : v;
   endfunction

   // angle of vector (d, n), pi = 2^31
   function automatic longint vector_angle(input longint n_in, input longint d_in);
      longint          n, d, t, acc;
      longint unsigned m;
      int              s;
      n   = n_in;
      d   = d_in;
      acc = 0;
      s   = 0;
      if (n == 0) return (d < 0) ? 64'sh8000_0000 : 0;
      if (d == 0) return (n > 0) ? 64'sh4000_0000 : -64'sh4000_0000;
      if (d < 0) begin
         t = d;
         if (n >= 0) begin
            d = n; n = -t; acc = 64'sh4000_0000;
         end else begin
            d = -n; n = t; acc = -64'sh4000_0000;
         end
      end
      m = magnitude(n) | magnitude(d);
      while ((m << 1) < (64'd1 << 59)) begin
         m <<= 1;
         s++;
      end
      n = n <<< s;
      d = d <<< s;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         t = d;
         if (n > 0) begin
            d   = d + (n >>> i);
            n   = n - (t >>> i);
            acc = acc + longint'(ATAN_TAB[i]);
         end else begin
            d   = d - (n >>> i);
            n   = n + (t >>> i);
            acc = acc - longint'(ATAN_TAB[i]);
         end
      end
      return acc;
   endfunction

   function automatic coords_type convert_point(input point_type p);
      coords_type      c;
      longint          x, y, z, lat;
      longint unsigned hsq, h, r;
      x   = longint'(p.x);
      y   = longint'(p.y);
      z   = longint'(p.z);
      hsq = magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y);
      h   = root_nearest(hsq);
      r   = root_nearest(hsq + magnitude(z) * magnitude(z));
      lat = 64'sh4000_0000 - vector_angle(longint'(h), z);
      if (lat > 64'sh4000_0000) lat = 64'sh4000_0000;
      if (lat < -64'sh4000_0000) lat = -64'sh4000_0000;
      c.lon = XW'(vector_angle(y, x));
      c.lat = XW'(lat);
      c.rad = XW'(r);
      return c;
   endfunction

   task automatic report_mismatch(input string field, input logic [XW-1:0] got,
                                  input logic [XW-1:0] want);
      $display("mismatch on %s at result %0d: got %h, expected %h",
               field, n_checked, got, want);
      n_errors++;
   endtask

   task automatic add_point(input logic [XW-1:0] x, input logic [XW-1:0] y,
                            input logic [XW-1:0] z);
      point_type p;
      p.x = x; p.y = y; p.z = z; p.drain = 1'b0;
      pending_points.push_back(p);
      n_planned++;
   endtask

   task automatic add_drain();
      point_type p;
      p = '{default: 0};
      p.drain = 1'b1;
      pending_points.push_back(p);
   endtask

   // phase 0: sender idles 20%, receiver 76%; phase 1 swapped; phase 2 none
   always_comb begin
      if (n_sent < n_planned / 3) phase = 0;
      else if (n_sent < 2 * n_planned / 3) phase = 1;
      else phase = 2;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_pos_x <= '0;
         req_pos_y <= '0;
         req_pos_z <= '0;
      end else if (!req_valid || !req_stall) begin
         if (pending_points.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_points[0].drain) begin
            req_valid <= 1'b0;
            if (!req_valid && expected_coords.size() == 0) void'(pending_points.pop_front());
         end else if ((phase == 0 && $urandom_range(99) < 20) ||
                      (phase == 1 && $urandom_range(99) < 76)) begin
            req_valid <= 1'b0;
         end else begin
            point_type p;
            p = pending_points.pop_front();
            req_valid <= 1'b1;
            req_pos_x <= p.x;
            req_pos_y <= p.y;
            req_pos_z <= p.z;
            n_sent++;
         end
      end
   end

   // receiver stall and result checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (phase == 0) ? ($urandom_range(99) < 76) :
                      (phase == 1) ? ($urandom_range(99) < 20) : 1'b0;
         if (req_valid && !req_stall) begin
            point_type p;
            p.x = req_pos_x; p.y = req_pos_y; p.z = req_pos_z; p.drain = 1'b0;
            expected_coords.push_back(convert_point(p));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_coords.size() == 0) begin
               $display("unexpected transaction at output: %h %h %h",
                        rsp_longitude, rsp_latitude, rsp_radius);
               n_errors++;
            end else begin
               coords_type c;
               c = expected_coords.pop_front();
               if (rsp_longitude !== c.lon) report_mismatch("longitude", rsp_longitude, c.lon);
               if (rsp_latitude !== c.lat) report_mismatch("latitude", rsp_latitude, c.lat);
               if (rsp_radius !== c.rad) report_mismatch("radius", rsp_radius, c.rad);
            end
            n_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout: %0d results still outstanding", expected_coords.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [XW-1:0] a, b, c;
      int            kind;
      reset     = 1'b1;

      // directed: origin, axes, extremes, quadrants
      add_point(0, 0, 0);
      add_point(0, 0, 1000);
      add_point(0, 0, -1000);
      add_point(32'h8000_0000, 0, 0);             // negative x axis
      add_point(-5, 0, 0);
      add_point(7, 0, 0);
      add_point(0, 9, 0);
      add_point(0, -9, 0);
      add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      add_point(1, 1, 1);
      add_point(-1, -1, -1);
      add_point(-1, 1, 0);
      add_point(1, -1, 0);
      add_point(-3, -4, 12);
      add_point(0, 0, 32'h8000_0000);
      add_point(0, 0, 32'h7fff_ffff);
      add_point(1, 0, 32'h8000_0000);
      add_drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         a = $urandom; b = $urandom; c = $urandom;
         kind = $urandom_range(9);
         case (kind)
            0: begin a = $signed(a) >>> $urandom_range(31); b = $signed(b) >>> $urandom_range(31); end
            1: a = 0;
            2: b = 0;
            3: begin a = 0; b = 0; end
            4: c = 0;
            5: begin
               b = a;
               if ($urandom_range(1)) b = -a;
            end
            6: begin
               a = $signed(a) >>> 20; b = $signed(b) >>> 20; c = $signed(c) >>> 20;
            end
            default: ;
         endcase
         add_point(a, b, c);
         if (i == N_RANDOM / 2) add_drain();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_points.size() != 0 || req_valid) @(posedge clock);
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("checked %0d conversions of %0d points: axes, origin, extremes and random",
               n_checked, n_sent);
      $display("octants under sender and receiver idling, with drains");
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
